// ===== rtl/core/dqe_pkg.sv =====
// Shared constants, widths and phase helpers for the debounced quadrature encoder.
package dqe_pkg;

  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 24;
  localparam int IN_TIME_W   = 32;
  localparam int POS_W       = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_GAP = 2'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd100;
  localparam logic [CFG_W-1:0] STEP_GAP_RESET = 16'd20;

  localparam logic [1:0] PHASE_00 = 2'b00;
  localparam logic [1:0] PHASE_01 = 2'b01;
  localparam logic [1:0] PHASE_11 = 2'b11;
  localparam logic [1:0] PHASE_10 = 2'b10;

  localparam logic signed [1:0] HALF_POS  = 2'sd1;
  localparam logic signed [1:0] HALF_NEG  = -2'sd1;
  localparam logic signed [1:0] HALF_ZERO = 2'sd0;

  // Forward Gray sequence: 00 -> 01 -> 11 -> 10 -> 00
  function automatic logic is_forward(input logic [1:0] from, input logic [1:0] to);
    logic fwd;
    case (from)
      PHASE_00: fwd = (to == PHASE_01);
      PHASE_01: fwd = (to == PHASE_11);
      PHASE_11: fwd = (to == PHASE_10);
      PHASE_10: fwd = (to == PHASE_00);
      default:  fwd = 1'b0;
    endcase
    return fwd;
  endfunction

endpackage

// ===== rtl/core/dqe_debounce.sv =====
// One debounced channel: level and time of its last accepted change.
module dqe_debounce #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      level_in,
  input  logic [TIME_WIDTH-1:0]     now,
  input  logic [dqe_pkg::CFG_W-1:0] gap,
  output logic                      level_next,
  output logic                      changed
);
  import dqe_pkg::*;

  logic                  level;
  logic [TIME_WIDTH-1:0] change_time;
  logic [TIME_WIDTH-1:0] diff;

  assign diff       = now - change_time;
  assign changed    = (level_in != level) && (diff > TIME_WIDTH'(gap));
  assign level_next = changed ? level_in : level;

  always_ff @(posedge clk) begin
    if (rst) begin
      level       <= 1'b1;
      change_time <= '0;
    end else if (en && changed) begin
      level       <= level_in;
      change_time <= now;
    end
  end

endmodule

// ===== rtl/core/dqe_step.sv =====
// Phase tracker: gap check on phase changes, half-step state and position count.
module dqe_step #(
  parameter int COUNT_WIDTH = 16,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [1:0]                phase,
  input  logic [TIME_WIDTH-1:0]     now,
  input  logic [dqe_pkg::CFG_W-1:0] gap,
  output logic [COUNT_WIDTH-1:0]    count,
  output logic [COUNT_WIDTH-1:0]    count_next,
  output logic signed [1:0]         half_step
);
  import dqe_pkg::*;

  logic [1:0]             prev_phase;
  logic [TIME_WIDTH-1:0]  phase_change_time;
  logic [TIME_WIDTH-1:0]  diff;
  logic                   step;
  logic signed [1:0]      half_step_next;

  assign diff = now - phase_change_time;
  assign step = (phase != prev_phase) && (diff > TIME_WIDTH'(gap));

  always_comb begin
    half_step_next = half_step;
    count_next     = count;
    if (step) begin
      if (is_forward(prev_phase, phase)) begin
        if (half_step == HALF_POS) begin
          half_step_next = HALF_ZERO;
          count_next     = count + COUNT_WIDTH'(1);
        end else begin
          half_step_next = half_step + HALF_POS;
        end
      end else begin
        if (half_step == HALF_NEG) begin
          half_step_next = HALF_ZERO;
          count_next     = count - COUNT_WIDTH'(1);
        end else begin
          half_step_next = half_step + HALF_NEG;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_phase        <= PHASE_00;
      phase_change_time <= '0;
      half_step         <= HALF_ZERO;
      count             <= '0;
    end else if (en) begin
      half_step <= half_step_next;
      count     <= count_next;
      if (step) begin
        prev_phase        <= phase;
        phase_change_time <= now;
      end
    end
  end

endmodule

// ===== rtl/core/debounced_quadrature_encoder.sv =====
// Top level: debounced quadrature encoder with push button, stream in and out.
// Path from input transaction to result: input register, then result register.
// Throughput: one transaction per cycle; all per-poll work is one pass of compare logic.
// Input and result registers decouple the sides; a stalled result holds the input stage.
// Reset (rst, synchronous): levels idle high, times, phase, half step and count cleared,
// debounce_ms = 100, step_gap_ms = 20, both stages empty.
module debounced_quadrature_encoder #(
  parameter int COUNT_WIDTH = 16,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dqe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dqe_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // time_ms[31:0], a_level[32], b_level[33], button_level[34], zero pad
  input  logic [dqe_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // position[15:0], pressed[16], phase_a[17], phase_b[18], zero pad
  output logic [dqe_pkg::OUT_DATA_W-1:0] m_tdata
);
  import dqe_pkg::*;

  logic [CFG_W-1:0]       debounce_ms;
  logic [CFG_W-1:0]       step_gap_ms;

  logic                   in_valid;
  logic [TIME_WIDTH-1:0]  in_time;
  logic                   in_a;
  logic                   in_b;
  logic                   in_btn;
  logic                   adv;

  logic                   a_next;
  logic                   b_next;
  logic                   btn_next;
  logic                   a_changed;
  logic                   b_changed;
  logic                   btn_changed;
  logic                   button_down;
  logic                   button_down_next;

  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic signed [1:0]      half_step;

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
      step_gap_ms <= STEP_GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE: debounce_ms <= cfg_data;
        REG_STEP_GAP: step_gap_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_time <= s_tdata[TIME_WIDTH-1:0];
      in_a    <= s_tdata[IN_TIME_W];
      in_b    <= s_tdata[IN_TIME_W+1];
      in_btn  <= s_tdata[IN_TIME_W+2];
    end
  end

  dqe_debounce #(.TIME_WIDTH(TIME_WIDTH)) u_deb_a (
    .clk(clk), .rst(rst), .en(adv), .level_in(in_a), .now(in_time),
    .gap(debounce_ms), .level_next(a_next), .changed(a_changed)
  );

  dqe_debounce #(.TIME_WIDTH(TIME_WIDTH)) u_deb_b (
    .clk(clk), .rst(rst), .en(adv), .level_in(in_b), .now(in_time),
    .gap(debounce_ms), .level_next(b_next), .changed(b_changed)
  );

  dqe_debounce #(.TIME_WIDTH(TIME_WIDTH)) u_deb_btn (
    .clk(clk), .rst(rst), .en(adv), .level_in(in_btn), .now(in_time),
    .gap(debounce_ms), .level_next(btn_next), .changed(btn_changed)
  );

  assign button_down_next = btn_changed ? !btn_next : button_down;

  always_ff @(posedge clk) begin
    if (rst) begin
      button_down <= 1'b0;
    end else if (adv) begin
      button_down <= button_down_next;
    end
  end

  dqe_step #(.COUNT_WIDTH(COUNT_WIDTH), .TIME_WIDTH(TIME_WIDTH)) u_step (
    .clk(clk), .rst(rst), .en(adv), .phase({a_next, b_next}), .now(in_time),
    .gap(step_gap_ms), .count(count), .count_next(count_next), .half_step(half_step)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {(OUT_DATA_W-POS_W-3)'(0), b_next, a_next, button_down_next,
                  POS_W'(count_next)};
    end
  end

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(count))
    else $error("count moved without a transaction");

  a_count_clears_half: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (half_step == HALF_ZERO))
    else $error("count stepped with half step pending");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");

  a_phase_a_follows: assert property (@(posedge clk) disable iff (rst)
    (adv && a_changed) |=> (m_tdata[POS_W+1] == $past(in_a)))
    else $error("accepted phase A change not in result");

  a_phase_b_follows: assert property (@(posedge clk) disable iff (rst)
    (adv && b_changed) |=> (m_tdata[POS_W+2] == $past(in_b)))
    else $error("accepted phase B change not in result");

endmodule

// ===== tb/tb.sv =====
// Testbench for the debounced quadrature encoder: stream stimulus, predictor and scoreboard.
module tb;
  import dqe_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_POLLS = 140;
  localparam int SETTING_PHASES = 8;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             pressed;
    logic             phase_a;
    logic             phase_b;
  } reading_t;

  class encoder_scoreboard;
    logic [CFG_W-1:0]     debounce_ms;
    logic [CFG_W-1:0]     step_gap_ms;
    logic                 lvl_a;
    logic                 lvl_b;
    logic                 lvl_btn;
    logic [IN_TIME_W-1:0] a_since;
    logic [IN_TIME_W-1:0] b_since;
    logic [IN_TIME_W-1:0] btn_since;
    logic [IN_TIME_W-1:0] step_since;
    logic [1:0]           last_phase;
    int                   half_steps;
    logic [POS_W-1:0]     count;
    logic                 pressed;
    reading_t             expected_readings[$];
    int                   errors;

    function new();
      debounce_ms = DEBOUNCE_RESET;
      step_gap_ms = STEP_GAP_RESET;
      lvl_a = 1'b1;
      lvl_b = 1'b1;
      lvl_btn = 1'b1;
      a_since = '0;
      b_since = '0;
      btn_since = '0;
      step_since = '0;
      last_phase = 2'b00;
      half_steps = 0;
      count = '0;
      pressed = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_DEBOUNCE: debounce_ms = val;
        REG_STEP_GAP: step_gap_ms = val;
        default: ;
      endcase
    endfunction

    // wrapping difference, strictly greater than the threshold
    function bit waited(logic [IN_TIME_W-1:0] now, logic [IN_TIME_W-1:0] since,
                        logic [CFG_W-1:0] gap);
      logic [IN_TIME_W-1:0] diff;
      diff = now - since;
      return diff > IN_TIME_W'(gap);
    endfunction

    function void track_poll(logic [IN_TIME_W-1:0] now, logic a, logic b, logic btn);
      logic [1:0] phase;
      reading_t   r;
      if (a != lvl_a && waited(now, a_since, debounce_ms)) begin
        lvl_a = a;
        a_since = now;
      end
      if (b != lvl_b && waited(now, b_since, debounce_ms)) begin
        lvl_b = b;
        b_since = now;
      end
      if (btn != lvl_btn && waited(now, btn_since, debounce_ms)) begin
        lvl_btn = btn;
        btn_since = now;
        pressed = !btn;
      end
      phase = {lvl_a, lvl_b};
      if (phase != last_phase && waited(now, step_since, step_gap_ms)) begin
        if (phase == {last_phase[0], ~last_phase[1]}) begin
          half_steps++;
          if (half_steps >= 2) begin
            half_steps = 0;
            count = count + 1'b1;
          end
        end else begin
          half_steps--;
          if (half_steps <= -2) begin
            half_steps = 0;
            count = count - 1'b1;
          end
        end
        last_phase = phase;
        step_since = now;
      end
      r.position = count;
      r.pressed = pressed;
      r.phase_a = lvl_a;
      r.phase_b = lvl_b;
      expected_readings.push_back(r);
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data);
      reading_t got;
      reading_t want;
      got.position = data[15:0];
      got.pressed = data[16];
      got.phase_a = data[17];
      got.phase_b = data[18];
      if (expected_readings.size() == 0) begin
        report_mismatch("result transaction with no poll pending");
      end else begin
        want = expected_readings.pop_front();
        if (got.position !== want.position)
          report_mismatch($sformatf("position got %0d want %0d",
                                    $signed(got.position), $signed(want.position)));
        if (got.pressed !== want.pressed)
          report_mismatch($sformatf("pressed got %b want %b", got.pressed, want.pressed));
        if (got.phase_a !== want.phase_a)
          report_mismatch($sformatf("phase_a got %b want %b", got.phase_a, want.phase_a));
        if (got.phase_b !== want.phase_b)
          report_mismatch($sformatf("phase_b got %b want %b", got.phase_b, want.phase_b));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  encoder_scoreboard sb = new();

  bit                   idle_on = 1'b1;
  int                   stall_left = 0;
  int                   cycles = 0;
  logic [IN_TIME_W-1:0] clock_ms = 32'h0000_1000;
  logic [1:0]           walk = 2'b11;
  bit                   walk_fwd = 1'b1;
  bit                   btn_raw = 1'b1;

  debounced_quadrature_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // result side back-pressure
  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // entered and left at a falling edge; tvalid stays high on return
  task automatic send_poll(logic [IN_TIME_W-1:0] t, logic a, logic b, logic btn);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, btn, b, a, t};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.track_poll(t, a, b, btn);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic apply_settings(int p);
    logic [CFG_W-1:0] deb;
    logic [CFG_W-1:0] gap;
    case (p)
      0: begin deb = 16'd0; gap = 16'd0; end
      1: begin deb = 16'hFFFF; gap = 16'hFFFF; end
      2: begin deb = 16'hFFFF; gap = 16'd0; end
      3: begin deb = 16'd0; gap = 16'hFFFF; end
      4: begin
        deb = CFG_W'($urandom_range(0, 65535));
        gap = CFG_W'($urandom_range(0, 65535));
      end
      5: begin deb = 16'd1; gap = 16'd1; end
      6: begin
        deb = CFG_W'($urandom_range(0, 50));
        gap = CFG_W'($urandom_range(0, 50));
      end
      default: begin deb = DEBOUNCE_RESET; gap = STEP_GAP_RESET; end
    endcase
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_STEP_GAP, gap);
    if (p % 2 == 1) begin
      write_reg(REG_SPARE_2, CFG_W'($urandom));
      write_reg(REG_SPARE_3, CFG_W'($urandom));
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_directed();
    send_poll(32'd0, 1'b1, 1'b1, 1'b1);
    send_poll(32'd20, 1'b1, 1'b1, 1'b1);
    send_poll(32'd21, 1'b1, 1'b1, 1'b1);
    send_poll(32'd100, 1'b0, 1'b1, 1'b1);
    send_poll(32'd101, 1'b0, 1'b1, 1'b1);
    send_poll(32'd102, 1'b0, 1'b1, 1'b0);
    send_poll(32'd150, 1'b0, 1'b0, 1'b0);
    send_poll(32'd160, 1'b1, 1'b0, 1'b0);
    send_poll(32'd202, 1'b1, 1'b0, 1'b1);
    send_poll(32'd203, 1'b1, 1'b0, 1'b1);
    // time runs backwards
    send_poll(32'd5, 1'b1, 1'b1, 1'b1);
    send_poll(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1);
    // forward Gray cycle across the time wrap
    send_poll(32'h0000_006F, 1'b1, 1'b1, 1'b1);
    send_poll(32'h0000_00E0, 1'b1, 1'b0, 1'b1);
    send_poll(32'h0000_0150, 1'b0, 1'b0, 1'b1);
    send_poll(32'h0000_01C0, 1'b0, 1'b1, 1'b1);
    send_poll(32'h0000_0230, 1'b1, 1'b1, 1'b1);
    send_poll(32'h0000_02A0, 1'b1, 1'b0, 1'b1);
    send_poll(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0);
    send_poll(32'h8000_0000, 1'b1, 1'b1, 1'b1);
    send_poll(32'hAAAA_5555, 1'b0, 1'b1, 1'b0);
    send_poll(32'h5555_AAAA, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic random_polls(int n);
    logic [IN_TIME_W-1:0] dt;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 80) begin
        case ($urandom_range(0, 5))
          0: dt = IN_TIME_W'(sb.debounce_ms);
          1: dt = IN_TIME_W'(sb.debounce_ms) + 1;
          2: dt = IN_TIME_W'(sb.step_gap_ms);
          3: dt = IN_TIME_W'(sb.step_gap_ms) + 1;
          4: dt = $urandom_range(0, sb.debounce_ms + sb.step_gap_ms + 2);
          default: dt = $urandom_range(0, 1 << 20);
        endcase
        if ($urandom_range(0, 7) == 0) walk_fwd = !walk_fwd;
        if ($urandom_range(0, 3) != 0)
          walk = walk_fwd ? {walk[0], ~walk[1]} : {~walk[0], walk[1]};
        if ($urandom_range(0, 5) == 0) btn_raw = !btn_raw;
        clock_ms = clock_ms + dt;
      end else begin
        walk = 2'($urandom_range(0, 3));
        btn_raw = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 2))
          0: clock_ms = $urandom;
          1: clock_ms = clock_ms - $urandom_range(1, 5000);
          default: ;
        endcase
      end
      send_poll(clock_ms, walk[1], walk[0], btn_raw);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    run_directed();
    for (int p = 0; p < SETTING_PHASES; p++) begin
      drain();
      idle_on = !(p == 3 || p == SETTING_PHASES - 1);
      if (p == 2 || p == 6) clock_ms = 32'hFFFF_F000;
      apply_settings(p);
      random_polls(PHASE_POLLS);
    end
    s_tvalid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dqe_pkg.sv
rtl/core/dqe_debounce.sv
rtl/core/dqe_step.sv
rtl/core/debounced_quadrature_encoder.sv
tb/tb.sv
